// ----- sv/adc_avg_pkg.sv -----
// Shared types, constants and functions for the ADC averaging LED bar meter.
// No dependencies; imported by the accumulator, display and top-level modules.
package adc_avg_pkg;

	localparam int unsigned FullScale  = 4060;
	localparam int unsigned PercentMax = 100;
	localparam int unsigned LedCount   = 8;
	localparam int unsigned PctBits    = 7;
	localparam int unsigned IdxBits    = 3;
	localparam int unsigned LvlBits    = 12;
	localparam int unsigned ExtBits    = 16;
	// 100/4060 reduces to 5/203
	localparam int unsigned RatioNum   = 5;
	localparam int unsigned RatioDen   = 203;
	localparam int unsigned DivBits    = 15;
	// ceil(2^22 / 203); exact floor for every numerator below 2^15
	localparam int unsigned RecipShift = 22;
	localparam int unsigned RecipMul   = 20662;
	localparam int unsigned ProdBits   = 30;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_BUTTON = 1'b1
	} op_t;

	typedef struct packed {
		logic step;
		logic toggle;
	} step_ctrl_t;

	// ceil(lvl * 5 / 203) by reciprocal multiplication; lvl below full scale
	function automatic logic [PctBits-1:0] pct_of_level(input logic [LvlBits-1:0] lvl);
		logic [DivBits-1:0]  num;
		logic [ProdBits-1:0] prod;
		num  = DivBits'(lvl) * DivBits'(RatioNum) + DivBits'(RatioDen - 1);
		prod = ProdBits'(num) * ProdBits'(RecipMul);
		return prod[RecipShift+PctBits-1:RecipShift];
	endfunction

	// floor(pct / 12.5), capped at the last LED
	function automatic logic [IdxBits-1:0] led_index(input logic [PctBits-1:0] pct);
		logic [IdxBits-1:0] idx;
		logic [PctBits:0]   dbl;
		dbl = {pct, 1'b0};
		idx = '0;
		for (int k = 1; k < LedCount; k++) begin
			if (dbl >= (PctBits+1)'(25 * k))
				idx = IdxBits'(k);
		end
		return idx;
	endfunction

endpackage

// ----- sv/adc_avg_accum.sv -----
// Sample accumulator, held level and display mode state.
// Depends on adc_avg_pkg for the step control struct.
module adc_avg_accum #(
	parameter int unsigned SAMPLE_BITS   = 12,
	parameter int unsigned AVERAGE_SHIFT = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  adc_avg_pkg::step_ctrl_t  ctrl,
	input  logic [SAMPLE_BITS-1:0]   sample,
	output logic [SAMPLE_BITS-1:0]   level_next,
	output logic                     mode_next
);
	import adc_avg_pkg::*;

	localparam int unsigned SumBits = SAMPLE_BITS + AVERAGE_SHIFT;

	logic [SumBits-1:0]       sum_q;
	logic [AVERAGE_SHIFT-1:0] count_q;
	logic [SAMPLE_BITS-1:0]   level_q;
	logic                     mode_q;

	logic [SumBits-1:0] sum_add;
	logic               block_done;
	logic               take;

	assign take       = ctrl.step && !ctrl.toggle;
	assign sum_add    = sum_q + SumBits'(sample);
	assign block_done = (count_q == {AVERAGE_SHIFT{1'b1}});
	assign level_next = (take && block_done) ? sum_add[SumBits-1:AVERAGE_SHIFT] : level_q;
	assign mode_next  = (ctrl.step && ctrl.toggle) ? !mode_q : mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			level_q <= '0;
			mode_q  <= 1'b0;
		end else if (ctrl.step) begin
			level_q <= level_next;
			mode_q  <= mode_next;
			if (take) begin
				if (block_done) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= sum_add;
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

endmodule

// ----- sv/adc_avg_display.sv -----
// Level to percent, LED index and LED pattern conversion.
// Depends on adc_avg_pkg for the percent and index functions.
module adc_avg_display #(
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  logic [SAMPLE_BITS-1:0]                  level,
	input  logic                                    bar_mode,
	output logic [adc_avg_pkg::PctBits-1:0]         percent,
	output logic [adc_avg_pkg::LedCount-1:0]        led_pattern
);
	import adc_avg_pkg::*;

	logic [ExtBits-1:0] level_ext;
	logic [IdxBits-1:0] idx;

	assign level_ext = ExtBits'(level);
	assign percent   = (level_ext >= ExtBits'(FullScale)) ? PctBits'(PercentMax)
	                                                      : pct_of_level(level_ext[LvlBits-1:0]);
	assign idx       = led_index(percent);

	always_comb begin
		for (int i = 0; i < LedCount; i++) begin
			if (bar_mode)
				led_pattern[i] = (IdxBits'(i) <= idx);
			else
				led_pattern[i] = (IdxBits'(i) == idx);
		end
	end

endmodule

// ----- sv/adc_average_led_bargraph_unit.sv -----
// Channel  Dir  Fields (tdata/tuser, low bit first)
// s_axis   in   tuser: operation; tdata: sample, zero padded to bytes
// m_axis   out  tdata: led_pattern, percent, level, bar_mode, zero padded to bytes
//
// Two register stages: input register, then result register.
// One transaction per cycle sustained; m_tready low stalls both stages when both are full.
// arst_n clears valid flags, sums, count, held level and mode (dot display).
// Top level of the ADC averaging LED bar meter; uses adc_avg_pkg, accum and display.
module adc_average_led_bargraph_unit #(
	parameter int unsigned SAMPLE_BITS   = 12,
	parameter int unsigned AVERAGE_SHIFT = 4
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]         s_tdata,  // sample
	input  logic                                     s_tuser,  // operation
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	output logic [((SAMPLE_BITS+16+7)/8)*8-1:0]      m_tdata   // led_pattern, percent, level, bar_mode
);
	import adc_avg_pkg::*;

	localparam int unsigned OutBits  = LedCount + PctBits + SAMPLE_BITS + 1;
	localparam int unsigned OutWidth = ((SAMPLE_BITS + 16 + 7) / 8) * 8;

	logic                   valid_s1;
	op_t                    op_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   valid_s2;
	logic [OutBits-1:0]     result_s2;

	logic                   advance;
	step_ctrl_t             ctrl;
	logic [SAMPLE_BITS-1:0] level_next;
	logic                   mode_next;
	logic [PctBits-1:0]     percent;
	logic [LedCount-1:0]    led_pattern;

	assign advance     = !valid_s2 || m_tready;
	assign s_tready    = !valid_s1 || advance;
	assign ctrl.step   = valid_s1 && advance;
	assign ctrl.toggle = (op_s1 == OP_BUTTON);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1     <= op_t'(s_tuser);
			sample_s1 <= s_tdata[SAMPLE_BITS-1:0];
		end
	end

	adc_avg_accum #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.AVERAGE_SHIFT (AVERAGE_SHIFT)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.sample     (sample_s1),
		.level_next (level_next),
		.mode_next  (mode_next)
	);

	adc_avg_display #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_display (
		.level       (level_next),
		.bar_mode    (mode_next),
		.percent     (percent),
		.led_pattern (led_pattern)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			result_s2 <= {mode_next, level_next, percent, led_pattern};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = OutWidth'(result_s2);

endmodule

// ----- sv/adc_avg_checker.sv -----
// Port-level checks for the ADC averaging LED bar meter, bound to the top level.
// Depends on adc_avg_pkg for field widths and the percent limit.
module adc_avg_checker #(
	parameter int unsigned SAMPLE_BITS = 12
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [((SAMPLE_BITS+16+7)/8)*8-1:0] m_tdata
);
	import adc_avg_pkg::*;

	localparam int unsigned PctLo  = LedCount;
	localparam int unsigned ModeAt = LedCount + PctBits + SAMPLE_BITS;

	logic [LedCount-1:0] leds;
	logic [PctBits-1:0]  pct;
	logic                bar;

	assign leds = m_tdata[LedCount-1:0];
	assign pct  = m_tdata[PctLo+PctBits-1:PctLo];
	assign bar  = m_tdata[ModeAt];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

	a_dot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !bar |-> $onehot(leds))
		else $error("dot mode pattern not one-hot");

	a_bar: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && bar |-> leds[0] && (((leds + 1'b1) & leds) == '0))
		else $error("bar mode pattern not filled from LED 0");

	a_pct: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && s_tvalid |-> pct <= PctBits'(PercentMax))
		else $error("percent above limit");

endmodule

bind adc_average_led_bargraph_unit adc_avg_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_adc_avg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- sim/adc_average_led_bargraph_unit_test.sv -----
// Self-checking testbench for adc_average_led_bargraph_unit: stream stimulus with
// bursts, gaps and receiver stalls, checked against a cycle-free meter predictor.
// Depends on adc_avg_pkg and the unit under test; reads no files.
`timescale 1ns / 100ps

module adc_average_led_bargraph_unit_test;

	import adc_avg_pkg::*;

	localparam int unsigned AvgShift   = 4;
	localparam int unsigned AvgLast    = (1 << AvgShift) - 1;
	localparam int unsigned RandItems  = 1000;
	localparam int unsigned HoldCycles = 120;
	localparam int unsigned CycleLimit = 200000;

	typedef struct packed {
		logic       bar_mode;
		logic [11:0] level;
		logic [6:0]  percent;
		logic [7:0]  led_pattern;
	} meter_display_t;

	class bargraph_tracker;
		logic [15:0]    acc_sum;
		logic [3:0]     acc_count;
		logic [11:0]    held_level;
		logic           bar_on;
		int unsigned    errors;
		meter_display_t expected_displays[$];

		function new();
			acc_sum    = '0;
			acc_count  = '0;
			held_level = '0;
			bar_on     = 1'b0;
			errors     = 0;
		endfunction

		function meter_display_t predict_display(input op_t op, input logic [11:0] smp);
			meter_display_t d;
			logic [15:0]    sum;
			int unsigned    pct;
			int unsigned    idx;
			if (op == OP_SAMPLE) begin
				sum = acc_sum + 16'(smp);
				if (acc_count >= 4'(AvgLast)) begin
					held_level = 12'(sum >> AvgShift);
					acc_sum    = '0;
					acc_count  = '0;
				end else begin
					acc_sum   = sum;
					acc_count = acc_count + 4'd1;
				end
			end else begin
				bar_on = ~bar_on;
			end
			pct = (int'(held_level) * 100 + FullScale - 1) / FullScale;
			if (pct > PercentMax)
				pct = PercentMax;
			idx = (pct * 2) / 25;
			if (idx > LedCount - 1)
				idx = LedCount - 1;
			d.led_pattern = bar_on ? 8'((2 << idx) - 1) : 8'(1 << idx);
			d.percent     = 7'(pct);
			d.level       = held_level;
			d.bar_mode    = bar_on;
			return d;
		endfunction

		function void note_item(input op_t op, input logic [11:0] smp);
			expected_displays.push_back(predict_display(op, smp));
		endfunction

		function void check_display(input logic [31:0] word);
			meter_display_t exp_d;
			meter_display_t got;
			got = meter_display_t'(word[27:0]);
			if (expected_displays.size() == 0) begin
				$display("%0t: unexpected result transaction %h", $time, word);
				errors++;
				return;
			end
			exp_d = expected_displays.pop_front();
			if (got.led_pattern !== exp_d.led_pattern) begin
				$display("%0t: led_pattern expected %h got %h", $time,
					exp_d.led_pattern, got.led_pattern);
				errors++;
			end
			if (got.percent !== exp_d.percent) begin
				$display("%0t: percent expected %0d got %0d", $time, exp_d.percent, got.percent);
				errors++;
			end
			if (got.level !== exp_d.level) begin
				$display("%0t: level expected %0d got %0d", $time, exp_d.level, got.level);
				errors++;
			end
			if (got.bar_mode !== exp_d.bar_mode) begin
				$display("%0t: bar_mode expected %b got %b", $time, exp_d.bar_mode, got.bar_mode);
				errors++;
			end
			if (word[31:28] !== 4'h0) begin
				$display("%0t: padding expected 0 got %h", $time, word[31:28]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // sample
	logic        s_tuser = 1'b0;  // operation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;  // led_pattern, percent, level, bar_mode

	logic        backpressure_request = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int unsigned random_sent = 0;

	bargraph_tracker tracker = new();

	adc_average_led_bargraph_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.note_item(op_t'(s_tuser), s_tdata[11:0]);
			if (m_tvalid && m_tready)
				tracker.check_display(m_tdata);
		end
	end

	// receiver: rotate stall patterns, serve one long hold-off on request
	initial begin
		int unsigned rx_cycle;
		int unsigned hold_left;
		bit          hold_served;
		rx_cycle    = 0;
		hold_left   = 0;
		hold_served = 0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (backpressure_request && !hold_served) begin
				hold_served = 1;
				hold_left   = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case ((rx_cycle >> 8) % 4)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					2: m_tready <= (rx_cycle[1:0] != 2'b00);
					default: m_tready <= ($urandom_range(0, 99) < 85);
				endcase
			end
		end
	end

	function automatic logic [11:0] clip_sample(input int v);
		if (v < 0)
			return 12'd0;
		if (v > 4095)
			return 12'hFFF;
		return 12'(v);
	endfunction

	task automatic offer_item(input op_t op, input logic [11:0] smp);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'h0, smp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic offer_paced(input op_t op, input logic [11:0] smp);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
				: $urandom_range(1, 16);
		end
		burst_left--;
		offer_item(op, smp);
		random_sent++;
		if (random_sent == 300)
			backpressure_request <= 1'b1;
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_displays.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int          target;
		int          spread;
		int unsigned kind;
		int unsigned n;
		bit          mid_drained;
		mid_drained = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// state straight after reset, both display modes
		offer_item(OP_BUTTON, 12'hFFF);
		offer_item(OP_BUTTON, 12'h000);
		// full-scale average: saturated percent, last LED
		for (int i = 0; i < 16; i++) begin
			if (i == 7)
				offer_item(OP_BUTTON, 12'hA5A);
			offer_item(OP_SAMPLE, 12'hFFF);
		end
		offer_item(OP_BUTTON, 12'h5A5);
		for (int i = 0; i < 4; i++)
			offer_item(OP_SAMPLE, 12'h000);
		wait_for_drain();

		while (random_sent < RandItems) begin
			if (!mid_drained && random_sent >= RandItems / 2) begin
				mid_drained = 1;
				wait_for_drain();
			end
			if ($urandom_range(0, 3) != 0) begin
				kind = $urandom_range(0, 3);
				case (kind)
					0: target = $urandom_range(0, 4095);
					1: target = $urandom_range(4040, 4095);
					2: target = int'($urandom_range(0, 100)) * int'(FullScale) / 100
						+ int'($urandom_range(0, 6)) - 3;
					default: target = $urandom_range(0, 40);
				endcase
				spread = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 64);
				for (int i = 0; i < 16; i++) begin
					if ($urandom_range(0, 99) < 8)
						offer_paced(OP_BUTTON, 12'($urandom));
					offer_paced(OP_SAMPLE,
						clip_sample(target + int'($urandom_range(0, 2 * spread)) - spread));
				end
			end else begin
				n = $urandom_range(1, 10);
				repeat (n) begin
					if ($urandom_range(0, 99) < 30)
						offer_paced(OP_BUTTON, 12'($urandom));
					else
						offer_paced(OP_SAMPLE, 12'($urandom));
				end
			end
		end

		wait_for_drain();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
